// ===== hw/rtl/cpcn_pkg.sv =====
// Shared constants and types for the circle pair collision normal block.
// No dependencies; imported by every module of the block.
`default_nettype none
package cpcn_pkg;
    localparam int COORD_WIDTH_DEF   = 24;
    localparam int DIR_FRAC_BITS_DEF = 14;
    localparam int PUSH_WIDTH        = 16;
    localparam int FLAG_WIDTH        = 2;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic degen;
        logic hit;
    } cpcn_flags_t;
endpackage
`default_nettype wire

// ===== hw/rtl/cpcn_front.sv =====
// Front end: differences, squares, hit test and degenerate detection (three stages).
// Depends on cpcn_pkg.
`default_nettype none
module cpcn_front import cpcn_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] first_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_y,
    input  wire logic        [COORD_WIDTH-2:0] first_radius,
    input  wire logic signed [COORD_WIDTH-1:0] second_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_y,
    input  wire logic        [COORD_WIDTH-2:0] second_radius,
    output logic                               out_valid,
    output cpcn_flags_t                        out_flags,
    output logic [2*COORD_WIDTH+2:0]           out_dsq,
    output logic [2*COORD_WIDTH+1:0]           out_ux2,
    output logic [2*COORD_WIDTH+1:0]           out_uy2
);
    localparam int UW = COORD_WIDTH + 1;
    localparam int SW = 2 * UW;

    logic signed [UW-1:0] dx, dy;
    logic [UW-1:0] ux_next, uy_next;

    // stage 1
    logic                   v1_reg;
    logic [UW-1:0]          ux_reg, uy_reg;
    logic [COORD_WIDTH-1:0] rsum_reg;
    logic                   rzero1_reg, negx1_reg, negy1_reg;
    // stage 2
    logic                     v2_reg;
    logic [SW-1:0]            x2_reg, y2_reg;
    logic [2*COORD_WIDTH-1:0] r2_reg;
    logic                     rzero2_reg, negx2_reg, negy2_reg;
    // stage 3
    logic          v3_reg;
    cpcn_flags_t   flags_reg;
    logic [SW:0]   dsq_reg;
    logic [SW-1:0] ux2_reg, uy2_reg;
    logic [SW:0]   dsq_next;

    assign dx = {first_x[COORD_WIDTH-1], first_x} - {second_x[COORD_WIDTH-1], second_x};
    assign dy = {first_y[COORD_WIDTH-1], first_y} - {second_y[COORD_WIDTH-1], second_y};
    assign ux_next = dx[UW-1] ? UW'(-dx) : UW'(dx);
    assign uy_next = dy[UW-1] ? UW'(-dy) : UW'(dy);
    assign dsq_next = {1'b0, x2_reg} + {1'b0, y2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ux_reg     <= ux_next;
            uy_reg     <= uy_next;
            rsum_reg   <= {1'b0, first_radius} + {1'b0, second_radius};
            rzero1_reg <= (first_radius == '0);
            negx1_reg  <= dx[UW-1];
            negy1_reg  <= dy[UW-1];

            x2_reg     <= ux_reg * ux_reg;
            y2_reg     <= uy_reg * uy_reg;
            r2_reg     <= rsum_reg * rsum_reg;
            rzero2_reg <= rzero1_reg;
            negx2_reg  <= negx1_reg;
            negy2_reg  <= negy1_reg;

            dsq_reg         <= dsq_next;
            ux2_reg         <= x2_reg;
            uy2_reg         <= y2_reg;
            flags_reg.hit   <= (dsq_next <= (SW+1)'(r2_reg));
            flags_reg.degen <= rzero2_reg || (dsq_next == '0);
            flags_reg.neg_x <= negx2_reg;
            flags_reg.neg_y <= negy2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_flags = flags_reg;
    assign out_dsq   = dsq_reg;
    assign out_ux2   = ux2_reg;
    assign out_uy2   = uy2_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/cpcn_dir_step.sv =====
// One bit of the direction search for both axes: trial subtract on the residual.
// Depends on cpcn_pkg.
`default_nettype none
module cpcn_dir_step import cpcn_pkg::*; #(
    parameter int WW  = 81,
    parameter int DW  = 51,
    parameter int QW  = 15,
    parameter int BIT = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire cpcn_flags_t   in_flags,
    input  wire logic [DW-1:0] in_dsq,
    input  wire logic [WW-1:0] in_rx,
    input  wire logic [WW-1:0] in_yx,
    input  wire logic [QW-1:0] in_qx,
    input  wire logic [WW-1:0] in_ry,
    input  wire logic [WW-1:0] in_yy,
    input  wire logic [QW-1:0] in_qy,
    output logic               out_valid,
    output cpcn_flags_t        out_flags,
    output logic [DW-1:0]      out_dsq,
    output logic [WW-1:0]      out_rx,
    output logic [WW-1:0]      out_yx,
    output logic [QW-1:0]      out_qx,
    output logic [WW-1:0]      out_ry,
    output logic [WW-1:0]      out_yy,
    output logic [QW-1:0]      out_qy
);
    // candidate q + 2^b costs 2^(b+1)*q*D + 2^(2b)*D more than q
    logic [WW-1:0] d_ext, dlt_x, dlt_y;
    logic          take_x, take_y;
    logic          v_reg;
    cpcn_flags_t   flags_reg;
    logic [DW-1:0] dsq_reg;
    logic [WW-1:0] rx_reg, yx_reg, ry_reg, yy_reg;
    logic [QW-1:0] qx_reg, qy_reg;

    assign d_ext  = WW'(in_dsq);
    assign dlt_x  = (in_yx << (BIT + 1)) + (d_ext << (2 * BIT));
    assign dlt_y  = (in_yy << (BIT + 1)) + (d_ext << (2 * BIT));
    assign take_x = (dlt_x <= in_rx);
    assign take_y = (dlt_y <= in_ry);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= in_flags;
            dsq_reg   <= in_dsq;
            rx_reg    <= take_x ? in_rx - dlt_x : in_rx;
            yx_reg    <= take_x ? in_yx + (d_ext << BIT) : in_yx;
            qx_reg    <= take_x ? (in_qx | (QW'(1) << BIT)) : in_qx;
            ry_reg    <= take_y ? in_ry - dlt_y : in_ry;
            yy_reg    <= take_y ? in_yy + (d_ext << BIT) : in_yy;
            qy_reg    <= take_y ? (in_qy | (QW'(1) << BIT)) : in_qy;
        end
    end

    assign out_valid = v_reg;
    assign out_flags = flags_reg;
    assign out_dsq   = dsq_reg;
    assign out_rx    = rx_reg;
    assign out_yx    = yx_reg;
    assign out_qx    = qx_reg;
    assign out_ry    = ry_reg;
    assign out_yy    = yy_reg;
    assign out_qy    = qy_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/circle_pair_collision_normal.sv =====
// Top level of the circle pair collision normal block.
// Depends on cpcn_pkg, cpcn_front and cpcn_dir_step.
`default_nettype none
// Takes one circle pair per request and returns hit, degenerate and the Q1.14
// unit push direction for circle A (truncated toward zero, sign applied after).
// One request is accepted every cycle while the output is not stalled; a result
// passes through three front stages, one stage per direction bit and one
// output register. A miss gives all zeros; a hit with zero radius A or
// coincident centres gives degenerate with a zero push. The whole pipeline
// advances together whenever the output register is empty or being taken, so
// s_tready follows m_tready combinationally.
module circle_pair_collision_normal import cpcn_pkg::*; #(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // first_x, first_y, first_radius, second_x, second_y, second_radius, zero pad
    input  wire logic [((6*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // push_x, push_y
    output logic [2*PUSH_WIDTH-1:0] m_tdata,
    // hit, degenerate
    output logic [FLAG_WIDTH-1:0]   m_tuser
);
    localparam int CW = COORD_WIDTH;
    localparam int F  = DIR_FRAC_BITS;
    localparam int DW = 2 * CW + 3;
    localparam int WW = DW + 2 * F + 2;
    localparam int QW = F + 1;
    localparam int NS = F + 1;

    logic en;

    // front outputs
    logic              fv;
    cpcn_flags_t       fflags;
    logic [DW-1:0]     fdsq;
    logic [2*CW+1:0]   fux2, fuy2;

    // direction search pipeline, index 0 feeds the first bit stage
    logic          sv    [0:NS];
    cpcn_flags_t   sfl   [0:NS];
    logic [DW-1:0] sdsq  [0:NS];
    logic [WW-1:0] srx   [0:NS];
    logic [WW-1:0] syx   [0:NS];
    logic [QW-1:0] sqx   [0:NS];
    logic [WW-1:0] sry   [0:NS];
    logic [WW-1:0] syy   [0:NS];
    logic [QW-1:0] sqy   [0:NS];

    logic                  out_valid_reg;
    logic [PUSH_WIDTH-1:0] push_x_reg, push_y_reg;
    logic                  hit_reg, degen_reg;
    logic [PUSH_WIDTH-1:0] mag_x, mag_y, push_x_next, push_y_next;
    logic                  keep;

    // advance everything when the output slot is free or draining
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    cpcn_front #(.COORD_WIDTH(CW)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_tvalid),
        .first_x       (s_tdata[CW-1:0]),
        .first_y       (s_tdata[2*CW-1:CW]),
        .first_radius  (s_tdata[3*CW-2:2*CW]),
        .second_x      (s_tdata[4*CW-2:3*CW-1]),
        .second_y      (s_tdata[5*CW-2:4*CW-1]),
        .second_radius (s_tdata[6*CW-3:5*CW-1]),
        .out_valid     (fv),
        .out_flags     (fflags),
        .out_dsq       (fdsq),
        .out_ux2       (fux2),
        .out_uy2       (fuy2)
    );

    // residual starts at u^2 * 2^(2F); q and q*D start at zero
    assign sv[0]   = fv;
    assign sfl[0]  = fflags;
    assign sdsq[0] = fdsq;
    assign srx[0]  = WW'(fux2) << (2 * F);
    assign sry[0]  = WW'(fuy2) << (2 * F);
    assign syx[0]  = '0;
    assign syy[0]  = '0;
    assign sqx[0]  = '0;
    assign sqy[0]  = '0;

    for (genvar i = 0; i < NS; i++) begin : g_step
        cpcn_dir_step #(.WW(WW), .DW(DW), .QW(QW), .BIT(F - i)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sv[i]),
            .in_flags  (sfl[i]),
            .in_dsq    (sdsq[i]),
            .in_rx     (srx[i]),
            .in_yx     (syx[i]),
            .in_qx     (sqx[i]),
            .in_ry     (sry[i]),
            .in_yy     (syy[i]),
            .in_qy     (sqy[i]),
            .out_valid (sv[i+1]),
            .out_flags (sfl[i+1]),
            .out_dsq   (sdsq[i+1]),
            .out_rx    (srx[i+1]),
            .out_yx    (syx[i+1]),
            .out_qx    (sqx[i+1]),
            .out_ry    (sry[i+1]),
            .out_yy    (syy[i+1]),
            .out_qy    (sqy[i+1])
        );
    end

    // only the low push bits reach the port, so negate in that width
    if (QW >= PUSH_WIDTH) begin : g_mag_trunc
        assign mag_x = sqx[NS][PUSH_WIDTH-1:0];
        assign mag_y = sqy[NS][PUSH_WIDTH-1:0];
    end else begin : g_mag_ext
        assign mag_x = PUSH_WIDTH'(sqx[NS]);
        assign mag_y = PUSH_WIDTH'(sqy[NS]);
    end

    assign keep        = sfl[NS].hit && !sfl[NS].degen;
    assign push_x_next = !keep ? '0 : (sfl[NS].neg_x ? -mag_x : mag_x);
    assign push_y_next = !keep ? '0 : (sfl[NS].neg_y ? -mag_y : mag_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= sv[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            push_x_reg <= push_x_next;
            push_y_reg <= push_y_next;
            hit_reg    <= sfl[NS].hit;
            degen_reg  <= sfl[NS].hit && sfl[NS].degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {push_y_reg, push_x_reg};
    assign m_tuser  = {degen_reg, hit_reg};
endmodule
`default_nettype wire

// ===== tb/cpcn_checker.sv =====
// Checker for the circle pair collision normal block: watches both channels,
// predicts each result from the accepted request and compares it field by field.
// Depends on cpcn_pkg for the result widths.
module cpcn_checker import cpcn_pkg::*; #(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
    parameter int SDATA_WIDTH   = ((6*COORD_WIDTH-2+7)/8)*8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [SDATA_WIDTH-1:0]  s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [2*PUSH_WIDTH-1:0] m_tdata,
    input  logic [FLAG_WIDTH-1:0]   m_tuser,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                           hit;
        logic                           degen;
        logic signed [PUSH_WIDTH-1:0]   px;
        logic signed [PUSH_WIDTH-1:0]   py;
    } contact_t;

    contact_t contact_q[$];

    // largest q with q*q*dsq <= u*u*2^(2F), built one bit at a time
    function automatic logic [63:0] push_magnitude(logic [63:0] u, logic [159:0] dsq);
        logic [159:0] target;
        logic [159:0] lhs;
        logic [63:0]  q;
        logic [63:0]  cand;
        q = 0;
        target = ({96'd0, u} * {96'd0, u}) << (2*DIR_FRAC_BITS);
        for (int b = DIR_FRAC_BITS; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            lhs = {96'd0, cand} * {96'd0, cand} * dsq;
            if (lhs <= target) q = cand;
        end
        return q;
    endfunction

    function automatic contact_t predict_contact(logic [SDATA_WIDTH-1:0] d);
        logic signed [63:0] ax, ay, bx, by, dx, dy;
        logic [63:0]  ra, rb, ux, uy, mx, my;
        logic [159:0] dsq, rsq;
        contact_t     c;
        ax = 64'(signed'(d[0*COORD_WIDTH +: COORD_WIDTH]));
        ay = 64'(signed'(d[1*COORD_WIDTH +: COORD_WIDTH]));
        ra = 64'(d[2*COORD_WIDTH +: COORD_WIDTH-1]);
        bx = 64'(signed'(d[3*COORD_WIDTH-1 +: COORD_WIDTH]));
        by = 64'(signed'(d[4*COORD_WIDTH-1 +: COORD_WIDTH]));
        rb = 64'(d[5*COORD_WIDTH-1 +: COORD_WIDTH-1]);
        dx = ax - bx;
        dy = ay - by;
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        dsq = {96'd0, ux} * {96'd0, ux} + {96'd0, uy} * {96'd0, uy};
        rsq = {96'd0, ra + rb} * {96'd0, ra + rb};
        c = '0;
        if (dsq > rsq) return c;
        c.hit = 1'b1;
        if (ra == 0 || dsq == 0) begin
            c.degen = 1'b1;
            return c;
        end
        mx = push_magnitude(ux, dsq);
        my = push_magnitude(uy, dsq);
        c.px = PUSH_WIDTH'(dx < 0 ? -mx : mx);
        c.py = PUSH_WIDTH'(dy < 0 ? -my : my);
        return c;
    endfunction

    assign pending = contact_q.size();

    always @(posedge aclk) begin
        contact_t want;
        contact_t got;
        if (!aresetn) begin
            contact_q.delete();
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) contact_q = {contact_q, predict_contact(s_tdata)};
            if (m_tvalid && m_tready) begin
                got.hit   = m_tuser[0];
                got.degen = m_tuser[1];
                got.px    = m_tdata[0 +: PUSH_WIDTH];
                got.py    = m_tdata[PUSH_WIDTH +: PUSH_WIDTH];
                if (contact_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = contact_q.pop_front();
                    if (want !== got) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the circle pair collision normal testbench: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on the block and cpcn_checker.
module testbench import cpcn_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW  = COORD_WIDTH_DEF;
    localparam int SDW = ((6*CW-2+7)/8)*8;
    localparam int LATENCY = DIR_FRAC_BITS_DEF + 5;
    localparam int CYCLE_LIMIT = 200000;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [SDW-1:0]          s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [2*PUSH_WIDTH-1:0] m_tdata;
    logic [FLAG_WIDTH-1:0]   m_tuser;
    int                      fail_count;
    int                      pending;
    int                      cycles = 0;
    bit                      steady = 1'b0;   // stretch with no idling on either side

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    circle_pair_collision_normal u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    cpcn_checker u_check (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .fail_count, .pending
    );

    // stall the result side at random with a 7 percent chance, except in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 7);
    end

    // abort on a hang
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic [SDW-1:0] pack_pair(logic [CW-1:0] ax, logic [CW-1:0] ay,
            logic [CW-2:0] ra, logic [CW-1:0] bx, logic [CW-1:0] by, logic [CW-2:0] rb);
        return SDW'({rb, by, bx, ra, ay, ax});
    endfunction

    // send one request; hold it until accepted, idling in front at random
    task automatic send_pair(logic [SDW-1:0] d);
        while (!steady && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // random circle pair; most are close enough to touch so hits are common
    function automatic logic [SDW-1:0] random_pair();
        logic [CW-1:0] ax, ay, bx, by;
        logic [CW-2:0] ra, rb;
        int mode;
        mode = $urandom_range(9);
        ax = CW'($urandom); ay = CW'($urandom);
        ra = (CW-1)'($urandom); rb = (CW-1)'($urandom);
        bx = CW'($urandom); by = CW'($urandom);
        if (mode < 6) begin
            // nearby pair with moderate radii
            ra = (CW-1)'($urandom_range(1 << 14));
            rb = (CW-1)'($urandom_range(1 << 14));
            bx = ax + CW'($urandom_range(1 << 15) - (1 << 14));
            by = ay + CW'($urandom_range(1 << 15) - (1 << 14));
            if (mode == 0) bx = ax;
            if (mode == 1) ra = '0;
        end else if (mode == 6) begin
            // tiny offsets test truncation near the axes
            bx = ax + CW'($urandom_range(6) - 3);
            by = ay + CW'($urandom_range(6) - 3);
        end
        return pack_pair(ax, ay, ra, bx, by, rb);
    endfunction

    localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-2:0] MAXR = '1;

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: miss, touch, coincident, zero radii, extremes, axis pushes
        send_pair(pack_pair(0, 0, 256, 24'd2000, 0, 256));
        send_pair(pack_pair(0, 0, 256, 24'd512, 0, 256));
        send_pair(pack_pair(0, 0, 256, 24'd513, 0, 256));
        send_pair(pack_pair(5, 7, 100, 5, 7, 3));
        send_pair(pack_pair(5, 7, 0, 5, 8, 3));
        send_pair(pack_pair(5, 7, 0, 5, 7, 0));
        send_pair(pack_pair(5, 7, 0, 5, 8, 0));
        send_pair(pack_pair(0, 0, 100, 0, -24'sd50, 0));
        send_pair(pack_pair(-24'sd50, 0, 100, 0, 0, 0));
        send_pair(pack_pair(3, 4, 10, 0, 0, 0));
        send_pair(pack_pair(-24'sd3, -24'sd4, 10, 0, 0, 0));
        send_pair(pack_pair(MAXC, MAXC, MAXR, MINC, MINC, MAXR));
        send_pair(pack_pair(MINC, MINC, MAXR, MAXC, MAXC, MAXR));
        send_pair(pack_pair(MAXC, MINC, 1, MINC, MAXC, 1));
        send_pair(pack_pair(MAXC, 0, MAXR, MINC, 0, MAXR));
        send_pair(pack_pair(0, MINC, MAXR, 0, MAXC, MAXR));
        send_pair(pack_pair(1, 1, MAXR, 0, 0, 0));
        send_pair(pack_pair(MAXC, MAXC, MAXR, MAXC, MAXC - 1'b1, MAXR));
        send_pair('1);

        for (int i = 0; i < 800; i++) begin
            steady = (i >= 300 && i < 420);
            send_pair(random_pair());
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
